// ===== rtl/contiguous_page_allocator_macros.svh =====
// Assertion macros shared by the checker of the contiguous page allocator.
// Depends on nothing; included by the checker file by its bare name.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("contiguous page allocator: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define CPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("contiguous page allocator: property violated");

`endif

// ===== rtl/cpa_pkg.sv =====
// Shared types and codes of the contiguous page allocator.
// Depends on nothing; used by the map cell, the top level and the checker.
package cpa_pkg;

	localparam int OP_W   = 2;
	localparam int SIZE_W = 17;
	localparam int ST_W   = 2;

	typedef logic [1:0] entry_t;

	// Page map entry codes; the fourth code is never written.
	localparam entry_t ENT_FREE  = 2'd0;
	localparam entry_t ENT_START = 2'd1;
	localparam entry_t ENT_CONT  = 2'd2;
	localparam entry_t ENT_RSVD  = 2'd3;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD      = 2'd1;
	localparam logic [ST_W-1:0] ST_NOROOM   = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTALLOC = 2'd3;

	// Control broadcast to every cell of the map ring.
	typedef struct packed {
		logic shift;
		logic clr;
	} cell_ctl_t;

endpackage

// ===== rtl/contiguous_page_allocator.sv =====
// An allocate scans the whole ring and, when a run is found, marks it in a second pass;
// a free makes one pass; a zero or oversized request, a clear and bad ops skip the passes.
// One transaction at a time: no new one is taken until the result is in the output register.
// Each pass is paced by the ring of map cells, which turns one page per cycle past
// a single read and write-back point. Reset (arst_n low) frees every page at once.
// Depends on cpa_pkg and cpa_cell.
module contiguous_page_allocator #(
	parameter int NUM_PAGES  = 256,
	parameter int PAGE_BYTES = 256,
	localparam int PG_W      = $clog2(NUM_PAGES + 1),
	localparam int IN_W      = ((cpa_pkg::OP_W + cpa_pkg::SIZE_W + PG_W + 7) / 8) * 8,
	localparam int OUT_W     = ((cpa_pkg::ST_W + PG_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // operation, size_bytes, page_number, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status, base_page, zero pad
);
	import cpa_pkg::*;

	localparam int PIDX_W = $clog2(NUM_PAGES);
	// A run's byte count stops growing once it covers the request, so it
	// never exceeds the largest request plus one page.
	localparam int RB_W = $clog2((1 << SIZE_W) + PAGE_BYTES);
	localparam logic [63:0] MAX_BYTES = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
	localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(NUM_PAGES - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MARK = 3'd2;
	localparam logic [2:0] S_FREE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// Fields of an incoming transaction.
	logic [OP_W-1:0]   in_op;
	logic [SIZE_W-1:0] in_size;
	logic [PG_W-1:0]   in_pg;

	assign in_op   = s_tdata[OP_W-1:0];
	assign in_size = s_tdata[OP_W +: SIZE_W];
	assign in_pg   = s_tdata[OP_W + SIZE_W +: PG_W];

	logic [2:0]        state_q;
	logic [PIDX_W-1:0] pos_q;       // page index currently at the head of the ring
	logic [SIZE_W-1:0] size_q;
	logic [PIDX_W-1:0] pg_idx_q;    // index of the page named by a free
	logic [RB_W-1:0]   run_bytes_q; // bytes covered by the current free run
	logic [PIDX_W-1:0] run_start_q;
	logic [PIDX_W-1:0] start_q;     // chosen run, first and last index
	logic [PIDX_W-1:0] end_q;
	logic              found_q;
	logic              walk_q;      // free walk still clearing continuations
	logic              nalloc_q;
	logic [ST_W-1:0]   res_st_q;
	logic [PG_W-1:0]   res_pg_q;
	logic              m_valid_q;
	logic [ST_W-1:0]   out_st_q;
	logic [PG_W-1:0]   out_pg_q;

	// The ring: each cell takes its neighbour's entry, the last cell takes the
	// written-back head entry, so after NUM_PAGES shifts the map is aligned again.
	cell_ctl_t cell_ctl;
	entry_t    cell_out [NUM_PAGES];
	entry_t    head;
	entry_t    wb;
	logic      accept;

	assign accept = s_tvalid && s_tready;
	assign head   = cell_out[0];

	assign cell_ctl.shift = (state_q == S_SCAN) || (state_q == S_MARK) || (state_q == S_FREE);
	assign cell_ctl.clr   = accept && (in_op == OP_CLEAR);

	for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
		entry_t cell_in;
		if (i == NUM_PAGES - 1) begin : g_tail
			assign cell_in = wb;
		end else begin : g_body
			assign cell_in = cell_out[i + 1];
		end
		cpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.din    (cell_in),
			.dout   (cell_out[i])
		);
	end

	// Per-cycle work on the head entry.
	logic [RB_W-1:0] run_bytes_inc;
	logic            fit_now;
	logic            hit_free_pg;
	logic            last_pos;

	assign run_bytes_inc = run_bytes_q + RB_W'(PAGE_BYTES);
	assign fit_now       = !found_q && (head == ENT_FREE) && (run_bytes_inc >= RB_W'(size_q));
	assign hit_free_pg   = (pos_q == pg_idx_q);
	assign last_pos      = (pos_q == LAST_IDX);

	always_comb begin
		wb = head;
		case (state_q)
			S_MARK: begin
				if (pos_q == start_q) begin
					wb = ENT_START;
				end else if (pos_q > start_q && pos_q <= end_q) begin
					wb = ENT_CONT;
				end
			end
			S_FREE: begin
				if (hit_free_pg) begin
					if (head != ENT_FREE) begin
						wb = ENT_FREE;
					end
				end else if (walk_q && (head == ENT_CONT || head == ENT_RSVD)) begin
					wb = ENT_FREE;
				end
			end
			default: begin
				wb = head;
			end
		endcase
	end

	// The result register is emptied by a taken result unless the finishing state
	// refills it in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_ALLOC: begin
								if (in_size == '0) begin
									state_q <= S_DONE;
								end else if (64'(in_size) > MAX_BYTES) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_FREE: begin
								if (in_pg == '0 || in_pg > PG_W'(NUM_PAGES)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_FREE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (last_pos) begin
						state_q <= (found_q || fit_now) ? S_MARK : S_DONE;
					end
				end
				S_MARK, S_FREE: begin
					if (last_pos) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they need no reset as the state machine qualifies them.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q       <= '0;
				run_bytes_q <= '0;
				run_start_q <= '0;
				found_q     <= 1'b0;
				walk_q      <= 1'b0;
				nalloc_q    <= 1'b0;
				size_q      <= in_size;
				pg_idx_q    <= PIDX_W'(in_pg - PG_W'(1));
				res_pg_q    <= '0;
				case (in_op)
					OP_ALLOC: res_st_q <= (in_size == '0) ? ST_BAD : ST_NOROOM;
					OP_FREE:  res_st_q <= ST_BAD;
					OP_CLEAR: res_st_q <= ST_OK;
					default:  res_st_q <= ST_BAD;
				endcase
			end
			S_SCAN: begin
				pos_q <= last_pos ? '0 : pos_q + PIDX_W'(1);
				if (!found_q) begin
					if (head == ENT_FREE) begin
						run_bytes_q <= run_bytes_inc;
						if (run_bytes_q == '0) begin
							run_start_q <= pos_q;
						end
					end else begin
						run_bytes_q <= '0;
					end
				end
				if (fit_now) begin
					found_q <= 1'b1;
					start_q <= (run_bytes_q == '0) ? pos_q : run_start_q;
					end_q   <= pos_q;
				end
				if (last_pos && !(found_q || fit_now)) begin
					res_st_q <= ST_NOROOM;
					res_pg_q <= '0;
				end
			end
			S_MARK: begin
				pos_q <= last_pos ? '0 : pos_q + PIDX_W'(1);
				if (last_pos) begin
					res_st_q <= ST_OK;
					res_pg_q <= PG_W'(start_q) + PG_W'(1);
				end
			end
			S_FREE: begin
				pos_q <= last_pos ? '0 : pos_q + PIDX_W'(1);
				if (hit_free_pg) begin
					nalloc_q <= (head == ENT_FREE);
					walk_q   <= (head != ENT_FREE);
				end else if (walk_q && !(head == ENT_CONT || head == ENT_RSVD)) begin
					walk_q <= 1'b0;
				end
				if (last_pos) begin
					if (nalloc_q || (hit_free_pg && head == ENT_FREE)) begin
						res_st_q <= ST_NOTALLOC;
						res_pg_q <= '0;
					end else begin
						res_st_q <= ST_OK;
						res_pg_q <= PG_W'(pg_idx_q) + PG_W'(1);
					end
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_st_q <= res_st_q;
					out_pg_q <= res_pg_q;
				end
			end
			default: begin
				pos_q <= '0;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({out_pg_q, out_st_q});

endmodule

// ===== rtl/cpa_cell.sv =====
// One page map entry of the allocator's ring of cells.
// Depends on cpa_pkg for the entry type and the cell control struct.
module cpa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cpa_pkg::cell_ctl_t ctl,
	input  cpa_pkg::entry_t   din,
	output cpa_pkg::entry_t   dout
);
	import cpa_pkg::*;

	entry_t entry_q;

	// A clear wins over a shift; the entry moves one place on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENT_FREE;
		end else if (ctl.clr) begin
			entry_q <= ENT_FREE;
		end else if (ctl.shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ===== rtl/cpa_checker.sv =====
// Port-level checker of the contiguous page allocator, bound to the top level.
// Depends on cpa_pkg and the assertion macros header.
`include "contiguous_page_allocator_macros.svh"

module cpa_checker #(
	parameter int NUM_PAGES = 256,
	parameter int PG_W      = 9,
	parameter int IN_W      = 32,
	parameter int OUT_W     = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);
	import cpa_pkg::*;

	logic [ST_W-1:0] st;
	logic [PG_W-1:0] pg;
	logic [OP_W-1:0] op;

	assign st = m_tdata[ST_W-1:0];
	assign pg = m_tdata[ST_W +: PG_W];
	assign op = s_tdata[OP_W-1:0];

	// A held result must not change.
	`CPA_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Items other than a clear are handled one at a time.
	`CPA_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready && op != OP_CLEAR, !s_tready)
	// Any failure reports page zero.
	`CPA_ASSERT_IMP(a_fail_page_zero, clk, arst_n, m_tvalid && st != ST_OK, pg == '0)
	// A reported page number never exceeds the page count of the map.
	`CPA_ASSERT_IMP(a_page_range, clk, arst_n, m_tvalid, pg <= PG_W'(NUM_PAGES))

endmodule

bind contiguous_page_allocator cpa_checker #(
	.NUM_PAGES (NUM_PAGES),
	.PG_W      (PG_W),
	.IN_W      (IN_W),
	.OUT_W     (OUT_W)
) u_cpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
